### hdl/srgb_pkg.sv
package srgb_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_RED_SHIFT   = 3'd0;
    localparam logic [2:0] CFG_GREEN_SHIFT = 3'd1;
    localparam logic [2:0] CFG_BLUE_SHIFT  = 3'd2;
    localparam logic [2:0] CFG_RED_MASK    = 3'd3;
    localparam logic [2:0] CFG_GREEN_MASK  = 3'd4;
    localparam logic [2:0] CFG_BLUE_MASK   = 3'd5;
    localparam logic [2:0] CFG_ALPHA_MASK  = 3'd6;

    // Operation codes carried in tuser.
    localparam logic FUNC_PACK   = 1'b0;
    localparam logic FUNC_UNPACK = 1'b1;

    // Luminance weights in per mille. Each weighted term is divided by 1000
    // through a reciprocal multiply: the products stay below 2^18, where
    // the rounded-up reciprocal of 2^28/1000 gives the exact floor.
    localparam int unsigned     LUMA_FRAC_BITS = 28;
    localparam longint unsigned LUMA_RECIP     = ((64'd1 << LUMA_FRAC_BITS) + 64'd999) / 64'd1000;
    localparam longint unsigned LUMA_COEF_R    = 64'd299 * LUMA_RECIP;
    localparam longint unsigned LUMA_COEF_G    = 64'd587 * LUMA_RECIP;
    localparam longint unsigned LUMA_COEF_B    = 64'd114 * LUMA_RECIP;
    localparam int unsigned     LUMA_PROD_W    = 36;

    // Replacement for a non-black color that packs to an empty word.
    localparam logic [15:0] BLACK_SUB = 16'h0001;

    // Scale arithmetic: 256 is unity, results saturate at 255.
    localparam int unsigned SCALE_FRAC_BITS = 8;
    localparam logic [7:0]  CHAN_MAX        = 8'hFF;

    // Stage 1: channel values ready for scaling (luminance in mono mode).
    typedef struct packed {
        logic        func;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [11:0] red_scale;
        logic [11:0] green_scale;
        logic [11:0] blue_scale;
        logic [15:0] pixel;
    } st1_t;

    // Stage 2: saturated scaled channels.
    typedef struct packed {
        logic       func;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [15:0] pixel;
    } st2_t;

    // Stage 3: the finished result.
    typedef struct packed {
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic [15:0] pixel;
    } res_t;

    // One truncated luminance term: floor(v * weight / 1000).
    function automatic logic [7:0] luma_term(input logic [7:0] v,
                                             input longint unsigned coef);
        logic [LUMA_PROD_W-1:0] prod;
        prod = LUMA_PROD_W'(v) * LUMA_PROD_W'(coef);
        return 8'(prod >> LUMA_FRAC_BITS);
    endfunction

    // Scale a channel by scale/256 and saturate to 255.
    function automatic logic [7:0] sat_scale(input logic [11:0] scale,
                                             input logic [7:0] v);
        logic [19:0] prod;
        logic [11:0] q;
        prod = 20'(scale) * 20'(v);
        q    = prod[19:SCALE_FRAC_BITS];
        return (q > 12'(CHAN_MAX)) ? CHAN_MAX : q[7:0];
    endfunction

    // Place a channel in the 16-bit word; the shift is 5-bit two's complement.
    function automatic logic [15:0] place_chan(input logic [7:0] c,
                                               input logic [4:0] s);
        logic [4:0]  n;
        logic [15:0] w;
        n = ~s + 5'd1;
        if (s[4]) begin
            w = {8'b0, c} >> n;
        end else begin
            w = {8'b0, c} << s[3:0];
        end
        return w;
    endfunction

    // Pull a channel out of the pixel and undo its placement shift.
    function automatic logic [7:0] extract_chan(input logic [15:0] pix,
                                                input logic [15:0] mask,
                                                input logic [4:0] s);
        logic [4:0]  n;
        logic [15:0] f;
        logic [15:0] w;
        n = ~s + 5'd1;
        f = pix & mask;
        if (s[4]) begin
            w = f << n;
        end else begin
            w = f >> s[3:0];
        end
        return w[7:0];
    endfunction

endpackage

### hdl/shaded_rgb_to_16bit_pixel_pack.sv
// Packs an 8-bit RGB color into a 16-bit pixel, or unpacks a pixel into
// RGB, one request per clock. tuser selects the operation (0 pack, 1
// unpack). Packing optionally reduces the color to luminance, scales each
// channel by scale/256 with saturation to 255, shifts each channel by its
// configured signed amount, masks it and ORs the channels together; a
// non-black color that packs to zero becomes 0x0001 with the alpha mask,
// and any other non-zero word gets the alpha mask. Unpacking masks the
// pixel per channel and reverses the shifts. The block is a three-stage
// pipeline (luminance multiply, scale multiply, shift and mask); a new
// request is taken every cycle unless the output stalls. Each stage has
// its own valid bit and holds while the stage after it is full and
// stalled. The user must write shift and mask registers through the cfg port
// only while no request is in flight; the block itself does not enforce it.
module shaded_rgb_to_16bit_pixel_pack
    import srgb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_data,

    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata from bit 0: red_in[7:0], green_in[15:8], blue_in[23:16],
    // red_scale[35:24], green_scale[47:36], blue_scale[59:48], mono[60],
    // pixel_in[76:61], zero[79:77].
    input  logic [79:0] s_tdata,
    // tuser: func.
    input  logic        s_tuser,

    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata from bit 0: pixel_out[15:0], red_out[23:16], green_out[31:24],
    // blue_out[39:32].
    output logic [39:0] m_tdata
);

    // Configuration registers.
    logic [4:0]  red_shift_reg;
    logic [4:0]  green_shift_reg;
    logic [4:0]  blue_shift_reg;
    logic [15:0] red_mask_reg;
    logic [15:0] green_mask_reg;
    logic [15:0] blue_mask_reg;
    logic [15:0] alpha_mask_reg;

    // Pipeline stages.
    logic  st1_valid_reg, st2_valid_reg, st3_valid_reg;
    st1_t  st1_reg, st1_next;
    st2_t  st2_reg, st2_next;
    res_t  st3_reg, st3_next;
    logic  st1_ready, st2_ready, st3_ready;

    // Input fields.
    logic [7:0]  in_red, in_green, in_blue;
    logic [11:0] in_red_scale, in_green_scale, in_blue_scale;
    logic        in_mono;
    logic [15:0] in_pixel;
    logic [8:0]  lum_sum;

    // Stage 3 intermediates.
    logic [15:0] packed_word;

    assign in_red         = s_tdata[7:0];
    assign in_green       = s_tdata[15:8];
    assign in_blue        = s_tdata[23:16];
    assign in_red_scale   = s_tdata[35:24];
    assign in_green_scale = s_tdata[47:36];
    assign in_blue_scale  = s_tdata[59:48];
    assign in_mono        = s_tdata[60];
    assign in_pixel       = s_tdata[76:61];

    assign cfg_ready = 1'b1;

    // Configuration writes; an index past the list is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_shift_reg   <= '0;
            green_shift_reg <= '0;
            blue_shift_reg  <= '0;
            red_mask_reg    <= '0;
            green_mask_reg  <= '0;
            blue_mask_reg   <= '0;
            alpha_mask_reg  <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                CFG_RED_SHIFT:   red_shift_reg   <= cfg_data[4:0];
                CFG_GREEN_SHIFT: green_shift_reg <= cfg_data[4:0];
                CFG_BLUE_SHIFT:  blue_shift_reg  <= cfg_data[4:0];
                CFG_RED_MASK:    red_mask_reg    <= cfg_data;
                CFG_GREEN_MASK:  green_mask_reg  <= cfg_data;
                CFG_BLUE_MASK:   blue_mask_reg   <= cfg_data;
                CFG_ALPHA_MASK:  alpha_mask_reg  <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Each stage moves when it is empty or the stage after it takes its data.
    assign st3_ready = !st3_valid_reg || m_tready;
    assign st2_ready = !st2_valid_reg || st3_ready;
    assign st1_ready = !st1_valid_reg || st2_ready;
    assign s_tready  = st1_ready;

    // Stage 1: luminance from three truncated weighted terms, used in place of the colors in mono mode.
    always_comb begin
        lum_sum = 9'(luma_term(in_red, LUMA_COEF_R))
                + 9'(luma_term(in_green, LUMA_COEF_G))
                + 9'(luma_term(in_blue, LUMA_COEF_B));
        st1_next.func        = s_tuser;
        st1_next.red_scale   = in_red_scale;
        st1_next.green_scale = in_green_scale;
        st1_next.blue_scale  = in_blue_scale;
        st1_next.pixel       = in_pixel;
        if (in_mono) begin
            st1_next.red   = lum_sum[7:0];
            st1_next.green = lum_sum[7:0];
            st1_next.blue  = lum_sum[7:0];
        end else begin
            st1_next.red   = in_red;
            st1_next.green = in_green;
            st1_next.blue  = in_blue;
        end
    end

    // Stage 2: per-channel gain with saturation.
    always_comb begin
        st2_next.func  = st1_reg.func;
        st2_next.pixel = st1_reg.pixel;
        st2_next.red   = sat_scale(st1_reg.red_scale, st1_reg.red);
        st2_next.green = sat_scale(st1_reg.green_scale, st1_reg.green);
        st2_next.blue  = sat_scale(st1_reg.blue_scale, st1_reg.blue);
    end

    // Stage 3: placement into the word, or extraction from the pixel.
    always_comb begin
        packed_word = (place_chan(st2_reg.red, red_shift_reg) & red_mask_reg)
                    | (place_chan(st2_reg.green, green_shift_reg) & green_mask_reg)
                    | (place_chan(st2_reg.blue, blue_shift_reg) & blue_mask_reg);
        if (st2_reg.func == FUNC_UNPACK) begin
            st3_next.pixel = '0;
            st3_next.red   = extract_chan(st2_reg.pixel, red_mask_reg, red_shift_reg);
            st3_next.green = extract_chan(st2_reg.pixel, green_mask_reg, green_shift_reg);
            st3_next.blue  = extract_chan(st2_reg.pixel, blue_mask_reg, blue_shift_reg);
        end else begin
            st3_next.red   = st2_reg.red;
            st3_next.green = st2_reg.green;
            st3_next.blue  = st2_reg.blue;
            // A visible color that lands on no mask bit still must not read as black.
            priority if (packed_word != '0) begin
                st3_next.pixel = packed_word | alpha_mask_reg;
            end else if ((st2_reg.red | st2_reg.green | st2_reg.blue) != '0) begin
                st3_next.pixel = BLACK_SUB | alpha_mask_reg;
            end else begin
                st3_next.pixel = '0;
            end
        end
    end

    // Valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            st3_valid_reg <= 1'b0;
        end else begin
            if (st1_ready) begin
                st1_valid_reg <= s_tvalid;
            end
            if (st2_ready) begin
                st2_valid_reg <= st1_valid_reg;
            end
            if (st3_ready) begin
                st3_valid_reg <= st2_valid_reg;
            end
        end
    end

    // Stage data.
    always_ff @(posedge aclk) begin
        if (st1_ready) begin
            st1_reg <= st1_next;
        end
        if (st2_ready) begin
            st2_reg <= st2_next;
        end
        if (st3_ready) begin
            st3_reg <= st3_next;
        end
    end

    assign m_tvalid = st3_valid_reg;
    assign m_tdata  = st3_reg;

endmodule
